### hw/rtl/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// tcpq_pkg: shared types and codes for the two-class priority queue
// Action and status codes, data widths and the control bundle that the top
// level broadcasts to every cell of the queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

	localparam int VALUE_W  = 32;
	localparam int ACTION_W = 2;
	localparam int STATUS_W = 2;

	localparam logic [ACTION_W-1:0] ACT_APPEND   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_PRIORITY = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_REMOVE   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// Broadcast to every cell in the cycle an item is accepted.
	typedef struct packed {
		logic                      ins_en;     // insert that fits
		logic                      rem_en;     // remove from a non-empty queue
		logic                      tail_mode;  // insert position is the tail
		logic signed [VALUE_W-1:0] value;
		logic signed [VALUE_W-1:0] threshold;
	} tcpq_ctrl_t;

endpackage

### hw/rtl/tcpq_cell.sv
// ----------------------------------------------------------------------------
// tcpq_cell: one storage cell of the queue
// Holds one entry, extends the leading run toward its right neighbor and
// shifts in from the left on insert or from the right on remove.
// ----------------------------------------------------------------------------
module tcpq_cell
	import tcpq_pkg::*;
(
	input  logic                      clk,
	input  tcpq_ctrl_t                ctrl,
	input  logic                      valid,
	input  logic                      run_in,
	input  logic signed [VALUE_W-1:0] left_data,
	input  logic signed [VALUE_W-1:0] right_data,
	output logic                      run_out,
	output logic signed [VALUE_W-1:0] entry
);

	logic signed [VALUE_W-1:0] entry_q;
	logic                      keep_run;

	// A cell stays in the run ahead of the insert point when it is valid and,
	// for a priority insert, its own entry is above the threshold.
	assign keep_run = valid & (ctrl.tail_mode | (entry_q > ctrl.threshold));
	assign run_out  = run_in & keep_run;
	assign entry    = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins_en) begin
			if (run_in && !keep_run) begin
				entry_q <= ctrl.value;
			end else if (!run_in) begin
				entry_q <= left_data;
			end
		end else if (ctrl.rem_en) begin
			entry_q <= right_data;
		end
	end

endmodule

### hw/rtl/two_class_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// two_class_priority_queue_unit: ordered queue with priority insert
// Top level: decodes actions, keeps the entry count and registers results.
// ----------------------------------------------------------------------------
// The unit takes one item in every clock cycle: busy is always low, so an
// item is accepted at any edge where start is high. In the next cycle
// the result appears on removed_value, status and occupancy with done high
// for that single cycle; the receiver cannot stall it, so it must capture
// the result then. The cycle time is set by the run signal that ripples
// through the row of DEPTH cells to find the insert point, plus one signed
// 32-bit compare in each cell. The threshold may only be written while no
// item is in flight.
module two_class_priority_queue_unit
	import tcpq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [ACTION_W-1:0]           action,
	input  logic signed [VALUE_W-1:0]     value,
	input  logic                          threshold_we,
	input  logic signed [VALUE_W-1:0]     threshold_wdata,
	output logic                          done,
	output logic signed [VALUE_W-1:0]     removed_value,
	output logic [STATUS_W-1:0]           status,
	output logic [$clog2(DEPTH+1)-1:0]    occupancy
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic signed [VALUE_W-1:0] threshold_q;
	logic [CNT_W-1:0]          count_q;
	logic                      done_q;
	logic signed [VALUE_W-1:0] removed_q;
	logic [STATUS_W-1:0]       status_q;
	logic [CNT_W-1:0]          occupancy_q;

	logic                      is_insert;
	logic                      is_remove;
	logic                      full;
	logic                      empty;
	logic [CNT_W-1:0]          count_next;
	tcpq_ctrl_t                ctrl;

	logic signed [VALUE_W-1:0] entry_data [DEPTH];
	logic [DEPTH:0]            run;

	// The unit never holds off start.
	assign busy = 1'b0;

	assign is_insert = start & ((action == ACT_APPEND) | (action == ACT_PRIORITY));
	assign is_remove = start & (action == ACT_REMOVE);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);

	// A plain append, or a priority insert of a value that is not above the
	// threshold, goes to the tail: the run then covers every valid cell.
	always_comb begin
		ctrl.ins_en    = is_insert & ~full;
		ctrl.rem_en    = is_remove & ~empty;
		ctrl.tail_mode = (action != ACT_PRIORITY) | ~(value > threshold_q);
		ctrl.value     = value;
		ctrl.threshold = threshold_q;
	end

	always_comb begin
		count_next = count_q;
		if (ctrl.ins_en) begin
			count_next = count_q + CNT_W'(1);
		end else if (ctrl.rem_en) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	// The run starts at the head and stops at the first cell that is either
	// beyond the count or, for a priority insert, not above the threshold.
	assign run[0] = 1'b1;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                      cell_valid;
		logic signed [VALUE_W-1:0] left_d;
		logic signed [VALUE_W-1:0] right_d;

		assign cell_valid = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_d = value;
		end else begin : g_mid
			assign left_d = entry_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_d = entry_data[i];
		end else begin : g_body
			assign right_d = entry_data[i+1];
		end

		tcpq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.valid      (cell_valid),
			.run_in     (run[i]),
			.left_data  (left_d),
			.right_data (right_d),
			.run_out    (run[i+1]),
			.entry      (entry_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= VALUE_W'(59);
		end else if (threshold_we) begin
			threshold_q <= threshold_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_next;
			done_q  <= start;
		end
	end

	// Result fields are payload and need no reset; done qualifies them.
	always_ff @(posedge clk) begin
		removed_q   <= ctrl.rem_en ? entry_data[0] : '0;
		occupancy_q <= count_next;
		if (is_insert && full) begin
			status_q <= ST_FULL;
		end else if (is_remove && empty) begin
			status_q <= ST_EMPTY;
		end else begin
			status_q <= ST_OK;
		end
	end

	assign done          = done_q;
	assign removed_value = removed_q;
	assign status        = status_q;
	assign occupancy     = occupancy_q;

endmodule

### verif/tb_two_class_priority_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_class_priority_queue_unit: self-checking bench for the priority queue
// A queue of pending operations feeds a clocked driver that issues items,
// threshold writes and drain pauses. The driver also keeps a software copy
// of the queue and predicts each result. A clocked monitor checks every done
// strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_two_class_priority_queue_unit;
	import tcpq_pkg::*;

	localparam int DEPTH = 16;
	localparam int OCC_W = $clog2(DEPTH + 1);

	// The unused action code behaves as a no-op in the unit.
	localparam logic [ACTION_W-1:0] ACT_NOOP = 2'd3;

	localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VALUE_W-1:0] RESET_THRESHOLD = 32'sd59;

	// One entry of the stimulus list: an item, a threshold write, or a pause
	// that waits for every outstanding result before going on.
	typedef enum logic [1:0] {OP_ITEM, OP_THRESH, OP_DRAIN} stim_kind_t;

	typedef struct packed {
		stim_kind_t                kind;
		logic [ACTION_W-1:0]       act;
		logic signed [VALUE_W-1:0] val;
		logic [15:0]               gap;   // idle cycles after this entry
	} stim_op_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] removed;
		logic [STATUS_W-1:0]       status;
		logic [OCC_W-1:0]          occ;
	} queue_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	logic [ACTION_W-1:0]       action = ACT_APPEND;
	logic signed [VALUE_W-1:0] value = '0;
	logic                      threshold_we = 1'b0;
	logic signed [VALUE_W-1:0] threshold_wdata = '0;
	logic                      done;
	logic signed [VALUE_W-1:0] removed_value;
	logic [STATUS_W-1:0]       status;
	logic [OCC_W-1:0]          occupancy;

	stim_op_t                  pending_ops[$];
	queue_result_t             expected_results[$];
	logic signed [VALUE_W-1:0] shadow_entries[$];
	logic signed [VALUE_W-1:0] shadow_threshold = RESET_THRESHOLD;
	int unsigned               idle_left = 0;
	int unsigned               mismatches = 0;
	queue_result_t             oldest;

	two_class_priority_queue_unit #(
		.DEPTH(DEPTH)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.action         (action),
		.value          (value),
		.threshold_we   (threshold_we),
		.threshold_wdata(threshold_wdata),
		.done           (done),
		.removed_value  (removed_value),
		.status         (status),
		.occupancy      (occupancy)
	);

	always #6 clk = ~clk;

	// Hard stop in case the unit hangs or stops producing results.
	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// Apply one accepted item to the shadow queue and record what the unit
	// must answer. A priority value goes right behind the leading run of
	// entries that are above the threshold at this moment; anything else
	// lands at the tail.
	function automatic void apply_queue_action(input logic [ACTION_W-1:0] act,
			input logic signed [VALUE_W-1:0] v);
		queue_result_t r;
		int            pos;
		r.removed = '0;
		r.status  = ST_OK;
		if (act == ACT_APPEND || act == ACT_PRIORITY) begin
			if (shadow_entries.size() >= DEPTH) begin
				r.status = ST_FULL;
			end else if (act == ACT_PRIORITY && v > shadow_threshold) begin
				pos = 0;
				while (pos < shadow_entries.size() && shadow_entries[pos] > shadow_threshold)
					pos++;
				shadow_entries.insert(pos, v);
			end else begin
				shadow_entries.push_back(v);
			end
		end else if (act == ACT_REMOVE) begin
			if (shadow_entries.size() == 0)
				r.status = ST_EMPTY;
			else
				r.removed = shadow_entries.pop_front();
		end
		r.occ = OCC_W'(shadow_entries.size());
		expected_results.push_back(r);
	endfunction

	// Driver. At each edge it first books whatever the unit took at that
	// edge (item or threshold write), then picks what to drive next. An item
	// that meets busy high stays on the port until it is taken.
	always @(posedge clk or negedge arst_n) begin : driver
		logic                      nx_start;
		logic                      nx_we;
		logic [ACTION_W-1:0]       nx_act;
		logic signed [VALUE_W-1:0] nx_val;
		logic signed [VALUE_W-1:0] nx_wdata;
		if (!arst_n) begin
			start           <= 1'b0;
			action          <= ACT_APPEND;
			value           <= '0;
			threshold_we    <= 1'b0;
			threshold_wdata <= '0;
		end else begin
			if (start && !busy)
				apply_queue_action(action, value);
			if (threshold_we)
				shadow_threshold = threshold_wdata;
			nx_start = start && busy;
			nx_we    = 1'b0;
			nx_act   = action;
			nx_val   = value;
			nx_wdata = threshold_wdata;
			if (!nx_start) begin
				if (idle_left > 0) begin
					idle_left--;
				end else if (pending_ops.size() > 0) begin
					case (pending_ops[0].kind)
						OP_ITEM: begin
							nx_start  = 1'b1;
							nx_act    = pending_ops[0].act;
							nx_val    = pending_ops[0].val;
							idle_left = 32'(pending_ops[0].gap);
							void'(pending_ops.pop_front());
						end
						OP_THRESH: begin
							// Always queued behind a drain, so nothing is in flight.
							nx_we     = 1'b1;
							nx_wdata  = pending_ops[0].val;
							idle_left = 32'(pending_ops[0].gap);
							void'(pending_ops.pop_front());
						end
						default: begin
							// Hold the sender until every prediction has been met.
							if (expected_results.size() == 0 && !start) begin
								idle_left = 32'(pending_ops[0].gap);
								void'(pending_ops.pop_front());
							end
						end
					endcase
				end
			end
			start           <= nx_start;
			action          <= nx_act;
			value           <= nx_val;
			threshold_we    <= nx_we;
			threshold_wdata <= nx_wdata;
		end
	end

	task automatic report_field(input string field, input logic signed [VALUE_W-1:0] want,
			input logic signed [VALUE_W-1:0] got);
		$display("%0t: mismatch on %s, expected %0d, actual %0d", $time, field, want, got);
		mismatches++;
	endtask

	// Monitor. done marks a result for exactly one cycle; it is sampled at
	// the edge that closes that cycle and checked against the oldest
	// prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with nothing expected, expected none, actual %0d/%0d/%0d",
					$time, removed_value, status, occupancy);
				mismatches++;
			end else begin
				oldest = expected_results.pop_front();
				if (removed_value !== oldest.removed)
					report_field("removed_value", oldest.removed, removed_value);
				if (status !== oldest.status)
					report_field("status", VALUE_W'(oldest.status), VALUE_W'(status));
				if (occupancy !== oldest.occ)
					report_field("occupancy", VALUE_W'(oldest.occ), VALUE_W'(occupancy));
			end
		end
	end

	// Mostly back-to-back or short gaps, now and then a long one. A quiet
	// stretch forces full-rate issue.
	function automatic logic [15:0] pick_gap(input bit quiet);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50)
			return 16'd0;
		if (r < 90)
			return 16'($urandom_range(1, 3));
		return 16'($urandom_range(8, 40));
	endfunction

	function automatic void queue_item(input logic [ACTION_W-1:0] act,
			input logic signed [VALUE_W-1:0] v, input bit quiet);
		pending_ops.push_back('{OP_ITEM, act, v, pick_gap(quiet)});
	endfunction

	function automatic void queue_drain(input logic [15:0] hold);
		pending_ops.push_back('{OP_DRAIN, ACT_APPEND, '0, hold});
	endfunction

	// A new threshold goes in only after the queue of results has run dry.
	function automatic void queue_threshold(input logic signed [VALUE_W-1:0] thr);
		queue_drain(16'($urandom_range(0, 3)));
		pending_ops.push_back('{OP_THRESH, ACT_APPEND, thr, pick_gap(1'b0)});
	endfunction

	// Values cluster around the current threshold so that both classes and
	// the at-threshold boundary show up often, with extremes and full-width
	// random words mixed in.
	function automatic logic signed [VALUE_W-1:0] pick_value(
			input logic signed [VALUE_W-1:0] thr);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return thr + VALUE_W'($urandom_range(0, 4)) - 32'sd2;
		if (r < 40) begin
			case ($urandom_range(0, 3))
				0: return VAL_MIN;
				1: return VAL_MAX;
				2: return 32'sd0;
				default: return -32'sd1;
			endcase
		end
		return $urandom;
	endfunction

	initial begin : stimulus
		logic signed [VALUE_W-1:0] phase_thr[7];
		logic signed [VALUE_W-1:0] cur_thr;
		int unsigned               insert_pct;
		int unsigned               r;
		bit                        quiet;
		int                        i;
		int                        p;
		int                        n;

		// Directed part, threshold at its reset value of 59.
		// Remove from an empty queue, then the unused code on an empty queue.
		queue_item(ACT_REMOVE, 32'sh5A5A_A5A5, 1'b0);
		queue_item(ACT_NOOP, 32'sh1234_5678, 1'b0);
		// Priority insert into an empty queue becomes the head; the next one
		// just above the threshold lines up behind it.
		queue_item(ACT_PRIORITY, 32'sd100, 1'b0);
		queue_item(ACT_PRIORITY, 32'sd60, 1'b1);
		// At the threshold a value is not a priority value and goes to the tail.
		queue_item(ACT_APPEND, 32'sd59, 1'b1);
		queue_item(ACT_PRIORITY, 32'sd59, 1'b0);
		queue_item(ACT_PRIORITY, VAL_MAX, 1'b0);
		queue_item(ACT_APPEND, VAL_MIN, 1'b1);
		queue_item(ACT_PRIORITY, VAL_MIN, 1'b0);
		// Fill to the last slot.
		for (i = 0; i < 9; i++)
			queue_item(ACT_APPEND, 32'(i - 4), 1'b1);
		// Inserts into a full queue are dropped, the unused code stays a no-op.
		queue_item(ACT_APPEND, -32'sd7, 1'b0);
		queue_item(ACT_PRIORITY, 32'sd1000, 1'b0);
		queue_item(ACT_NOOP, VAL_MAX, 1'b0);
		for (i = 0; i < 4; i++)
			queue_item(ACT_REMOVE, $urandom, 1'b1);

		// Random part: one phase per threshold, the extremes among them.
		phase_thr[0] = VAL_MIN;
		phase_thr[1] = VAL_MAX;
		phase_thr[2] = 32'sd0;
		phase_thr[3] = -32'sd1;
		phase_thr[4] = $urandom;
		phase_thr[5] = 32'sd60;
		phase_thr[6] = RESET_THRESHOLD;
		for (p = 0; p < 7; p++) begin
			cur_thr = phase_thr[p];
			queue_threshold(cur_thr);
			for (n = 0; n < 120; n++) begin
				// Every 30 items the mix shifts between draining, balanced
				// and filling, so the queue swings between empty and full.
				if (n % 30 == 0) begin
					case ($urandom_range(0, 2))
						0: insert_pct = 25;
						1: insert_pct = 50;
						default: insert_pct = 75;
					endcase
					quiet = ($urandom_range(0, 3) == 0);
				end
				// In phases 2 and 5, pause the sender once mid-phase until every result is in.
				if (n == 60 && (p == 2 || p == 5))
					queue_drain(16'($urandom_range(5, 20)));
				r = $urandom_range(0, 99);
				if (r < 2)
					queue_item(ACT_NOOP, $urandom, quiet);
				else if (r < 2 + insert_pct)
					queue_item(($urandom_range(0, 9) < 6) ? ACT_PRIORITY : ACT_APPEND,
						pick_value(cur_thr), quiet);
				else
					queue_item(ACT_REMOVE, $urandom, quiet);
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || start || expected_results.size() != 0)
			@(posedge clk);
		// The extra edges catch any stray strobe.
		repeat (4) @(posedge clk);

		if (expected_results.size() != 0)
			$display("%0t: %0d results never arrived", $time, expected_results.size());
		if (mismatches == 0 && expected_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
